@@ rtl/core/tgd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_pkg
// Types and constants shared by the touch gesture detector modules.
// ----------------------------------------------------------------------------
package tgd_pkg;

    localparam int unsigned COORD_W  = 12;
    localparam int unsigned TIMER_W  = 16;
    localparam int unsigned LONG_W   = TIMER_W + 1;
    localparam int unsigned RADIUS_W = 26;
    localparam int unsigned DIST_W   = 2 * COORD_W + 1;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_DELAY       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_EXTRA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_RADIUS_SQ    = 2'd2;

    localparam logic [TIMER_W-1:0]  SHOW_DELAY_RST       = 16'd500;
    localparam logic [TIMER_W-1:0]  LONG_PRESS_EXTRA_RST = 16'd1000;
    localparam logic [RADIUS_W-1:0] TAP_RADIUS_SQ_RST    = 26'd1;

    typedef enum logic [1:0] {
        ACT_DOWN = 2'd0,
        ACT_UP   = 2'd1,
        ACT_MOVE = 2'd2,
        ACT_TICK = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        GES_DOWN = 3'd0,
        GES_TAP  = 3'd1,
        GES_SHOW = 3'd2,
        GES_LONG = 3'd3,
        GES_DRAG = 3'd4
    } t_gesture;

    typedef struct packed {
        logic [TIMER_W-1:0]  show_delay;
        logic [TIMER_W-1:0]  long_press_extra;
        logic [RADIUS_W-1:0] tap_radius_sq;
    } t_cfg;

    typedef struct packed {
        t_gesture           gesture;
        logic [COORD_W-1:0] new_x;
        logic [COORD_W-1:0] new_y;
        logic [COORD_W-1:0] old_x;
        logic [COORD_W-1:0] old_y;
    } t_result;

endpackage

@@ rtl/core/touch_gesture_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_detector
// Turns touch down, up, move and tick words into gesture reports.
// ----------------------------------------------------------------------------
// One input word is taken every clock cycle unless the input stalls; its
// report, if it causes one, is offered from the result register. The input
// register loads on acceptance; once the result buffer can take the report,
// the flag and timer updates load into the state registers and the report
// into the result register. A skid stage behind the result register keeps
// input flowing while the output stalls; the input stalls only once both
// result slots and the input register are full. Up words after a drag or
// long press, ticks that fire nothing and moves inside the tap radius give
// no report. Configuration is written through the plain write port; the user
// must do so only while the block is idle; the block does not enforce it.
module touch_gesture_detector
    import tgd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [RADIUS_W-1:0]   i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // touch_x [11:0], touch_y [23:12]
    input  logic [23:0]           s_axis_tdata,
    // action [1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // new_x [11:0], new_y [23:12], old_x [35:24], old_y [47:36]
    output logic [47:0]           m_axis_tdata,
    // gesture [2:0]
    output logic [2:0]            m_axis_tuser
);

    t_cfg    w_cfg;
    logic    w_can_take;
    logic    w_push;
    t_result w_core_res;
    t_result w_out_res;

    tgd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    tgd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_vld   (s_axis_tvalid),
        .o_in_rdy   (s_axis_tready),
        .i_action   (t_action'(s_axis_tuser)),
        .i_x        (s_axis_tdata[11:0]),
        .i_y        (s_axis_tdata[23:12]),
        .i_can_take (w_can_take),
        .o_push     (w_push),
        .o_res      (w_core_res)
    );

    tgd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_res      (w_core_res),
        .o_can_take (w_can_take),
        .o_vld      (m_axis_tvalid),
        .i_rdy      (m_axis_tready),
        .o_res      (w_out_res)
    );

    assign m_axis_tuser = w_out_res.gesture;
    assign m_axis_tdata = {w_out_res.old_y, w_out_res.old_x,
                           w_out_res.new_y, w_out_res.new_x};

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_can_take |-> !w_push)
        else $error("result pushed into full output buffer");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> !w_can_take)
        else $error("input stalled with room in output buffer");

    a_coords_only_on_drag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != GES_DRAG)) |-> (m_axis_tdata == '0))
        else $error("non-drag gesture carries coordinates");

    a_gesture_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= GES_DRAG))
        else $error("undefined gesture code on output");
`endif

endmodule

@@ rtl/core/tgd_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_cfg
// Configuration registers: timeouts and squared tap radius.
// ----------------------------------------------------------------------------
module tgd_cfg
    import tgd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [RADIUS_W-1:0]   i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHOW_DELAY:       n_cfg.show_delay       = i_cfg_wdata[TIMER_W-1:0];
                CFG_LONG_PRESS_EXTRA: n_cfg.long_press_extra = i_cfg_wdata[TIMER_W-1:0];
                CFG_TAP_RADIUS_SQ:    n_cfg.tap_radius_sq    = i_cfg_wdata;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.show_delay       <= SHOW_DELAY_RST;
            r_cfg.long_press_extra <= LONG_PRESS_EXTRA_RST;
            r_cfg.tap_radius_sq    <= TAP_RADIUS_SQ_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/tgd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_core
// Input word register, touch state and timers, one-pass gesture decision.
// ----------------------------------------------------------------------------
module tgd_core
    import tgd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_in_vld,
    output logic                o_in_rdy,
    input  t_action             i_action,
    input  logic [COORD_W-1:0]  i_x,
    input  logic [COORD_W-1:0]  i_y,
    input  logic                i_can_take,
    output logic                o_push,
    output t_result             o_res
);

    logic               r_in_vld;
    t_action            r_in_action;
    logic [COORD_W-1:0] r_in_x;
    logic [COORD_W-1:0] r_in_y;

    logic               r_pressed,    n_pressed;
    logic               r_dragging,   n_dragging;
    logic               r_long_prs,   n_long_prs;
    logic [COORD_W-1:0] r_last_x,     n_last_x;
    logic [COORD_W-1:0] r_last_y,     n_last_y;
    logic [TIMER_W-1:0] r_show_cnt,   n_show_cnt;
    logic               r_show_armed, n_show_armed;
    logic [LONG_W-1:0]  r_long_cnt,   n_long_cnt;
    logic               r_long_armed, n_long_armed;

    logic               w_adv;
    logic               w_res_vld;
    t_result            w_res;
    logic [COORD_W-1:0] w_dx;
    logic [COORD_W-1:0] w_dy;
    logic [DIST_W-1:0]  w_dist;
    logic               w_show_fired;

    assign w_adv    = r_in_vld && i_can_take;
    assign o_in_rdy = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_rdy) begin
            r_in_vld <= i_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_rdy && i_in_vld) begin
            r_in_action <= i_action;
            r_in_x      <= i_x;
            r_in_y      <= i_y;
        end
    end

    // squared distance from the press point
    assign w_dx   = (r_last_x > r_in_x) ? (r_last_x - r_in_x) : (r_in_x - r_last_x);
    assign w_dy   = (r_last_y > r_in_y) ? (r_last_y - r_in_y) : (r_in_y - r_last_y);
    assign w_dist = DIST_W'(w_dx * w_dx) + DIST_W'(w_dy * w_dy);

    assign w_show_fired = r_show_armed && (r_show_cnt <= TIMER_W'(1));

    always_comb begin
        n_pressed    = r_pressed;
        n_dragging   = r_dragging;
        n_long_prs   = r_long_prs;
        n_last_x     = r_last_x;
        n_last_y     = r_last_y;
        n_show_cnt   = r_show_cnt;
        n_show_armed = r_show_armed;
        n_long_cnt   = r_long_cnt;
        n_long_armed = r_long_armed;
        w_res_vld    = 1'b0;
        w_res        = '0;

        unique case (r_in_action)
            ACT_DOWN: begin
                n_last_x     = r_in_x;
                n_last_y     = r_in_y;
                n_show_cnt   = i_cfg.show_delay;
                n_show_armed = 1'b1;
                n_long_cnt   = LONG_W'(i_cfg.show_delay) + LONG_W'(i_cfg.long_press_extra);
                n_long_armed = 1'b1;
                n_pressed    = 1'b1;
                w_res_vld    = 1'b1;
                w_res.gesture = GES_DOWN;
            end
            ACT_UP: begin
                if (r_long_prs) begin
                    n_long_prs = 1'b0;
                end else if (!r_dragging) begin
                    w_res_vld     = 1'b1;
                    w_res.gesture = GES_TAP;
                end
                n_dragging   = 1'b0;
                n_pressed    = 1'b0;
                n_show_armed = 1'b0;
                n_long_armed = 1'b0;
            end
            ACT_MOVE: begin
                if (r_pressed) begin
                    if ({1'b0, w_dist} > i_cfg.tap_radius_sq) begin
                        n_pressed    = 1'b0;
                        n_dragging   = 1'b1;
                        n_show_armed = 1'b0;
                        n_long_armed = 1'b0;
                        w_res_vld    = 1'b1;
                    end
                end else if (r_dragging) begin
                    w_res_vld = (r_in_x != r_last_x) || (r_in_y != r_last_y);
                end
                if (w_res_vld) begin
                    w_res.gesture = GES_DRAG;
                    w_res.new_x   = r_in_x;
                    w_res.new_y   = r_in_y;
                    w_res.old_x   = r_last_x;
                    w_res.old_y   = r_last_y;
                    n_last_x      = r_in_x;
                    n_last_y      = r_in_y;
                end
            end
            ACT_TICK: begin
                if (r_show_armed) begin
                    if (w_show_fired) begin
                        n_show_armed = 1'b0;
                        n_show_cnt   = '0;
                    end else begin
                        n_show_cnt = r_show_cnt - TIMER_W'(1);
                    end
                end
                if (r_long_armed) begin
                    if (r_long_cnt <= LONG_W'(1)) begin
                        // held back one tick when show press fires together
                        if (!w_show_fired) begin
                            n_long_armed  = 1'b0;
                            n_long_cnt    = '0;
                            n_pressed     = 1'b0;
                            n_dragging    = 1'b0;
                            n_long_prs    = 1'b1;
                            w_res_vld     = 1'b1;
                            w_res.gesture = GES_LONG;
                        end
                    end else begin
                        n_long_cnt = r_long_cnt - LONG_W'(1);
                    end
                end
                if (w_show_fired) begin
                    w_res_vld     = 1'b1;
                    w_res.gesture = GES_SHOW;
                end
            end
            default: begin
                w_res_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed    <= 1'b0;
            r_dragging   <= 1'b0;
            r_long_prs   <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_show_cnt   <= '0;
            r_show_armed <= 1'b0;
            r_long_cnt   <= '0;
            r_long_armed <= 1'b0;
        end else if (w_adv) begin
            r_pressed    <= n_pressed;
            r_dragging   <= n_dragging;
            r_long_prs   <= n_long_prs;
            r_last_x     <= n_last_x;
            r_last_y     <= n_last_y;
            r_show_cnt   <= n_show_cnt;
            r_show_armed <= n_show_armed;
            r_long_cnt   <= n_long_cnt;
            r_long_armed <= n_long_armed;
        end
    end

    assign o_push = w_adv && w_res_vld;
    assign o_res  = w_res;

endmodule

@@ rtl/core/tgd_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgd_out_buf
// Result register with a skid stage towards the output stream.
// ----------------------------------------------------------------------------
module tgd_out_buf
    import tgd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_can_take,
    output logic    o_vld,
    input  logic    i_rdy,
    output t_result o_res
);

    logic    r_main_vld;
    logic    r_skid_vld;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;

    assign w_pop      = r_main_vld && i_rdy;
    assign o_can_take = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_vld && !w_pop) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_main_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_vld && !w_pop) begin
                r_skid <= i_res;
            end else begin
                r_main <= i_res;
            end
        end
    end

    assign o_vld = r_main_vld;
    assign o_res = r_main;

endmodule
